[rtl/websocket_frame_deframer_macros.svh]
// Assertion macros for the deframer's checker file.
// Depends on: nothing; a user must have clk and arst_n in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/wsd_pkg.sv]
// Package for the WebSocket frame deframer: result record, parser phases, codes.
// Depends on: nothing.
`default_nettype none

package wsd_pkg;

	// Result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;
	localparam logic [1:0] KIND_CLOSE   = 2'd3;

	// Error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_UNMASKED  = 3'd1;
	localparam logic [2:0] ERR_CONT      = 3'd2;
	localparam logic [2:0] ERR_RSV       = 3'd3;
	localparam logic [2:0] ERR_CTRL_FRAG = 3'd4;
	localparam logic [2:0] ERR_CTRL_SIZE = 3'd5;
	localparam logic [2:0] ERR_BAD_SIZE  = 3'd6;

	// Opcodes
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;

	// Length codes of the second header byte
	localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
	localparam logic [6:0] LEN_EXT16    = 7'd126;
	localparam logic [6:0] LEN_EXT64    = 7'd127;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXT_HI  = 3'd2,
		PH_EXT_LO  = 3'd3,
		PH_KEY     = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	// One classified result on its way from parser to output stage.
	// The back end forms payload_byte as data ^ key.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [7:0]  key;
		logic [3:0]  opcode;
		logic        last;
		logic [15:0] length;
		logic [2:0]  err;
	} rec_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage

`default_nettype wire

[rtl/wsd_front.sv]
// Front end of the deframer: header parser, mask key capture, result classification.
// Depends on: wsd_pkg.
`default_nettype none

module wsd_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_fire,
	input  wire logic [7:0]  rx_byte,
	output logic             push,
	output wsd_pkg::rec_t    rec
);
	import wsd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  flags_q, flags_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] remain_q, remain_d;
	logic [15:0] total_q, total_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  kidx_q, kidx_d;
	logic        halted_q, halted_d;

	logic [2:0]  hdr_err;
	logic [15:0] ext_len;
	logic        pay_last;
	logic        is_close;
	logic [7:0]  key_byte;

	// Header checks on the second header byte, in protocol priority order.
	always_comb begin
		hdr_err = ERR_NONE;
		priority if (!rx_byte[7]) begin
			hdr_err = ERR_UNMASKED;
		end else if (flags_q[3:0] == OP_CONT) begin
			hdr_err = ERR_CONT;
		end else if (flags_q[3:0] == OP_TEXT || flags_q[3:0] == OP_BINARY) begin
			if (flags_q[6:4] != 3'd0)
				hdr_err = ERR_RSV;
			else if (rx_byte[6:0] == LEN_EXT64)
				hdr_err = ERR_BAD_SIZE;
		end else if (!flags_q[7]) begin
			hdr_err = ERR_CTRL_FRAG;
		end else if (rx_byte[6:0] > LEN_CTRL_MAX) begin
			hdr_err = ERR_CTRL_SIZE;
		end else if (flags_q[6:4] != 3'd0) begin
			hdr_err = ERR_RSV;
		end else begin
			hdr_err = ERR_NONE;
		end
	end

	assign ext_len  = {len_hi_q, rx_byte};
	assign pay_last = (remain_q <= 16'd1);
	assign is_close = (flags_q[3:0] == OP_CLOSE);

	always_comb begin
		unique case (kidx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			2'd3: key_byte = key_q[7:0];
		endcase
	end

	// Next state
	always_comb begin
		phase_d  = phase_q;
		flags_d  = flags_q;
		len_hi_d = len_hi_q;
		remain_d = remain_q;
		total_d  = total_q;
		key_d    = key_q;
		kidx_d   = kidx_q;
		halted_d = halted_q;
		if (in_fire && !halted_q) begin
			case (phase_q)
				PH_HDR1: begin
					if (hdr_err != ERR_NONE) begin
						halted_d = 1'b1;
					end else begin
						kidx_d = 2'd0;
						key_d  = 32'd0;
						if (rx_byte[6:0] == LEN_EXT16) begin
							phase_d = PH_EXT_HI;
						end else begin
							total_d = {9'd0, rx_byte[6:0]};
							phase_d = PH_KEY;
						end
					end
				end
				PH_EXT_HI: begin
					len_hi_d = rx_byte;
					phase_d  = PH_EXT_LO;
				end
				PH_EXT_LO: begin
					if (ext_len < {9'd0, LEN_EXT16}) begin
						halted_d = 1'b1;
					end else begin
						total_d = ext_len;
						phase_d = PH_KEY;
					end
				end
				PH_KEY: begin
					key_d = {key_q[23:0], rx_byte};
					if (kidx_q != 2'd3) begin
						kidx_d = kidx_q + 2'd1;
					end else begin
						kidx_d   = 2'd0;
						remain_d = total_q;
						if (total_q == 16'd0) begin
							phase_d = PH_HDR0;
							if (is_close)
								halted_d = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					if (pay_last) begin
						remain_d = 16'd0;
						kidx_d   = 2'd0;
						phase_d  = PH_HDR0;
						if (is_close)
							halted_d = 1'b1;
					end else begin
						remain_d = remain_q - 16'd1;
						kidx_d   = kidx_q + 2'd1;
					end
				end
				default: begin
					// first header byte; unused phase codes land here too
					flags_d = rx_byte;
					phase_d = PH_HDR1;
				end
			endcase
		end
	end

	// Outputs: classify the accepted byte into at most one result record
	always_comb begin
		push       = 1'b0;
		rec.kind   = KIND_PAYLOAD;
		rec.data   = 8'd0;
		rec.key    = 8'd0;
		rec.opcode = flags_q[3:0];
		rec.last   = 1'b1;
		rec.length = 16'd0;
		rec.err    = ERR_NONE;
		if (in_fire && !halted_q) begin
			case (phase_q)
				PH_HDR1: begin
					if (hdr_err != ERR_NONE) begin
						push     = 1'b1;
						rec.kind = KIND_ERROR;
						rec.err  = hdr_err;
					end
				end
				PH_EXT_LO: begin
					if (ext_len < {9'd0, LEN_EXT16}) begin
						push     = 1'b1;
						rec.kind = KIND_ERROR;
						rec.err  = ERR_BAD_SIZE;
					end
				end
				PH_KEY: begin
					if (kidx_q == 2'd3 && total_q == 16'd0) begin
						push     = 1'b1;
						rec.kind = is_close ? KIND_CLOSE : KIND_EMPTY;
					end
				end
				PH_PAYLOAD: begin
					rec.length = total_q;
					if (is_close) begin
						push     = pay_last;
						rec.kind = KIND_CLOSE;
					end else begin
						push     = 1'b1;
						rec.data = rx_byte;
						rec.key  = key_byte;
						rec.last = pay_last;
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			flags_q  <= 8'd0;
			len_hi_q <= 8'd0;
			remain_q <= 16'd0;
			total_q  <= 16'd0;
			key_q    <= 32'd0;
			kidx_q   <= 2'd0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			flags_q  <= flags_d;
			len_hi_q <= len_hi_d;
			remain_q <= remain_d;
			total_q  <= total_d;
			key_q    <= key_d;
			kidx_q   <= kidx_d;
			halted_q <= halted_d;
		end
	end

endmodule

`default_nettype wire

[rtl/wsd_queue.sv]
// Short register queue of result records between parser and output stage.
// Depends on: wsd_pkg.
`default_nettype none

module wsd_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire wsd_pkg::rec_t  wr_rec,
	input  wire logic           pop,
	output wsd_pkg::rec_t       rd_rec,
	output wsd_pkg::q_status_t  status
);
	import wsd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	rec_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign status.full      = (count_q == FULL_CNT);
	assign status.not_empty = (count_q != '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && status.not_empty;
	assign rd_rec  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

[rtl/wsd_back.sv]
// Back end of the deframer: unmask the payload byte and hold the result register.
// Depends on: wsd_pkg.
`default_nettype none

module wsd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire wsd_pkg::q_status_t q_status,
	input  wire wsd_pkg::rec_t  q_rec,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [1:0]          kind,
	output logic [7:0]          payload_byte,
	output logic [3:0]          frame_opcode,
	output logic                frame_last,
	output logic [15:0]         frame_length,
	output logic [2:0]          fault_code
);
	import wsd_pkg::*;

	logic        valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [3:0]  opcode_q;
	logic        last_q;
	logic [15:0] length_q;
	logic [2:0]  err_q;

	// refill whenever the register is empty or its beat leaves this cycle
	assign pop = q_status.not_empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= q_rec.kind;
			byte_q   <= q_rec.data ^ q_rec.key;
			opcode_q <= q_rec.opcode;
			last_q   <= q_rec.last;
			length_q <= q_rec.length;
			err_q    <= q_rec.err;
		end
	end

	assign out_valid    = valid_q;
	assign kind         = kind_q;
	assign payload_byte = byte_q;
	assign frame_opcode = opcode_q;
	assign frame_last   = last_q;
	assign frame_length = length_q;
	assign fault_code   = err_q;

endmodule

`default_nettype wire

[rtl/websocket_frame_deframer.sv]
// Top level of the WebSocket client-to-server frame deframer.
// Depends on: wsd_pkg, wsd_front, wsd_queue, wsd_back.
//
//   channel | signals                         | width | beat
//   --------+---------------------------------+-------+--------------------------
//   in      | in_valid, in_ready, rx_byte     | 8     | one received stream byte
//   out     | out_valid, out_ready, kind,     | 34    | one result: payload byte,
//           | payload_byte, frame_opcode,     |       | empty frame, error or
//           | frame_last, frame_length,       |       | close received
//           | fault_code                      |       |
//
// One input beat per cycle while in_ready is high; a result is written into a
// queue slot at its acceptance edge and moves to the output register when free.
// in_ready drops only while all QUEUE_DEPTH queue slots hold results.
// Reset is asynchronous and active low and puts the parser at the first
// header byte. After an error or a close, input beats are still taken
// and dropped without result until reset.
`default_nettype none

module websocket_frame_deframer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       payload_byte,
	output logic [3:0]       frame_opcode,
	output logic             frame_last,
	output logic [15:0]      frame_length,
	output logic [2:0]       fault_code
);
	import wsd_pkg::*;

	logic      in_fire;
	logic      push;
	logic      pop;
	rec_t      front_rec;
	rec_t      head_rec;
	q_status_t q_status;

	// Accept whenever a slot is free; a beat produces at most one result,
	// so a free slot always has room for it.
	assign in_ready = !q_status.full;
	assign in_fire  = in_valid && in_ready;

	// Parse headers, capture the key and classify each accepted beat
	wsd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.rx_byte (rx_byte),
		.push    (push),
		.rec     (front_rec)
	);

	// Decouple parser from output back-pressure
	wsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (front_rec),
		.pop    (pop),
		.rd_rec (head_rec),
		.status (q_status)
	);

	// Unmask and hold the result beat until it is taken
	wsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.q_rec        (head_rec),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.frame_opcode (frame_opcode),
		.frame_last   (frame_last),
		.frame_length (frame_length),
		.fault_code   (fault_code)
	);

endmodule

`default_nettype wire

[rtl/wsd_checker.sv]
// Port-level checker for the deframer, bound to the top level.
// Depends on: wsd_pkg, websocket_frame_deframer_macros.svh.
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module wsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  kind,
	input wire logic [7:0]  payload_byte,
	input wire logic        frame_last,
	input wire logic [15:0] frame_length,
	input wire logic [2:0]  fault_code
);
	import wsd_pkg::*;

	`WSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(payload_byte), "result beat changed while stalled")
	`WSD_ASSERT_NOW(a_err_shape, out_valid && kind == KIND_ERROR, frame_last && frame_length == 16'd0 && fault_code != ERR_NONE, "malformed error beat")
	`WSD_ASSERT_NOW(a_code_only_err, out_valid && kind != KIND_ERROR, fault_code == ERR_NONE, "error code on non-error beat")
	`WSD_ASSERT_NOW(a_nonpay_shape, out_valid && kind != KIND_PAYLOAD, payload_byte == 8'd0 && frame_last, "non-payload beat carries data")
	`WSD_ASSERT_NEXT(a_halt_quiet, out_valid && out_ready && (kind == KIND_ERROR || kind == KIND_CLOSE), !out_valid, "result after error or close")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.payload_byte (payload_byte),
	.frame_last   (frame_last),
	.frame_length (frame_length),
	.fault_code   (fault_code)
);

`default_nettype wire
